/* rtl/nearest_smaller_value_stack_top_assert.svh */
// assertion macros for the nearest smaller value stack
`ifndef NEAREST_SMALLER_VALUE_STACK_TOP_ASSERT_SVH
`define NEAREST_SMALLER_VALUE_STACK_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NSV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NSV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nsv_pkg.sv */
// shared widths and register indexes for the nearest smaller value stack
package nsv_pkg;

    localparam int POS_W     = 16;
    localparam int COUNT_W   = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_BACKWARD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYS_SIGNED   = 2'd2;

endpackage

/* rtl/nsv_stack_mem.sv */
// stack storage for keys and positions, one write and one registered read port
module nsv_stack_mem
    import nsv_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int KEY_W = 32,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [KEY_W-1:0]  wr_key,
    input  logic [POS_W-1:0]  wr_pos,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_key,
    output logic [POS_W-1:0]  rd_pos
);

    logic [KEY_W+POS_W-1:0] mem [DEPTH];
    logic [KEY_W+POS_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_pos};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_key = rd_data_reg[KEY_W+POS_W-1:POS_W];
    assign rd_pos = rd_data_reg[POS_W-1:0];

endmodule

/* rtl/nsv_key_cmp.sv */
// shared key comparator, greater-or-equal in signed or unsigned order
module nsv_key_cmp
#(
    parameter int KEY_W = 32
)
(
    input  logic [KEY_W-1:0] a,
    input  logic [KEY_W-1:0] b,
    input  logic             signed_mode,
    output logic             a_ge_b
);

    logic [KEY_W-1:0] a_ord;
    logic [KEY_W-1:0] b_ord;

    // flipping the sign bit maps two's complement order onto unsigned order
    assign a_ord = {a[KEY_W-1] ^ signed_mode, a[KEY_W-2:0]};
    assign b_ord = {b[KEY_W-1] ^ signed_mode, b[KEY_W-2:0]};
    assign a_ge_b = a_ord >= b_ord;

endmodule

/* rtl/nearest_smaller_value_stack_top.sv */
// top level of the all nearest smaller values engine with its sequencer
// flow: an accepted key reads the stack top when the stack is not empty; the compare state
//   pops entries not below the key, one stack read per cycle through the shared compare, then
//   the push state pushes the key and loads the result register once it is free; keys are taken only in idle
// reset: stack empty, scan counter and overflow flag zero, element_count 1, forward,
//   unsigned; stack storage is not cleared and needs no clearing pass
`include "nearest_smaller_value_stack_top_assert.svh"

module nearest_smaller_value_stack_top
    import nsv_pkg::*;
#(
    parameter int STACK_DEPTH  = 1024,
    parameter int KEY_WIDTH    = 32,
    parameter int MAX_ELEMENTS = 65536,
    localparam int KEY_TDATA_W = ((KEY_WIDTH + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COUNT_W-1:0]     cfg_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [KEY_TDATA_W-1:0] s_tdata,   // key

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*POS_W-1:0]     m_tdata,   // position, nearest_position
    output logic [1:0]             m_tuser,   // has_smaller, stack_overflow
    output logic                   m_tlast    // end_of_sequence
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int LIMIT_INT = (MAX_ELEMENTS < 65536) ? MAX_ELEMENTS : 65536;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LIMIT_INT);
    localparam logic [FILL_W-1:0]  DEPTH_FILL  = FILL_W'(STACK_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [COUNT_W-1:0]   element_count_reg;
    logic                 scan_backward_reg;
    logic                 keys_signed_reg;

    logic [1:0]           state_reg, state_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [POS_W-1:0]     scan_reg, scan_next;
    logic                 ovf_reg, ovf_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 last_reg, last_next;
    logic                 has_reg, has_next;
    logic [POS_W-1:0]     near_reg, near_next;

    logic [2*POS_W-1:0]   m_tdata_reg;
    logic [1:0]           m_tuser_reg;
    logic                 m_tlast_reg;

    logic                 accept;
    logic                 push_go;
    logic                 full;
    logic [COUNT_W-1:0]   count_eff;
    logic [COUNT_W-1:0]   back_pos;
    logic [POS_W-1:0]     pos_calc;
    logic                 last_calc;

    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [POS_W-1:0]     rd_pos;
    logic                 wr_en;
    logic                 top_ge;

    nsv_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .KEY_W (KEY_WIDTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_key  (key_reg),
        .wr_pos  (pos_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_pos  (rd_pos)
    );

    nsv_key_cmp #(
        .KEY_W (KEY_WIDTH)
    ) u_cmp (
        .a           (rd_key),
        .b           (key_reg),
        .signed_mode (keys_signed_reg),
        .a_ge_b      (top_ge)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign push_go   = (state_reg == ST_PUSH) && (!m_tvalid_reg || m_tready);
    assign full      = (fill_reg == DEPTH_FILL);

    always_comb
    begin
        priority if (element_count_reg == '0)
        begin
            count_eff = COUNT_W'(1);
        end
        else if (element_count_reg > COUNT_LIMIT)
        begin
            count_eff = COUNT_LIMIT;
        end
        else
        begin
            count_eff = element_count_reg;
        end
    end

    assign back_pos  = count_eff - COUNT_W'(1) - COUNT_W'(scan_reg);
    assign pos_calc  = scan_backward_reg ? back_pos[POS_W-1:0] : scan_reg;
    assign last_calc = (COUNT_W'(scan_reg) + COUNT_W'(1)) >= count_eff;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        scan_next     = scan_reg;
        ovf_next      = ovf_reg;
        key_next      = key_reg;
        pos_next      = pos_reg;
        last_next     = last_reg;
        has_next      = has_reg;
        near_next     = near_reg;
        rd_en         = 1'b0;
        rd_addr       = ADDR_W'(fill_reg - FILL_W'(1));
        wr_en         = 1'b0;
        m_tvalid_next = m_tvalid_reg & ~m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next  = s_tdata[KEY_WIDTH-1:0];
                    pos_next  = pos_calc;
                    last_next = last_calc;
                    has_next  = 1'b0;
                    near_next = '0;
                    if (fill_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_CMP:
            begin
                rd_addr = ADDR_W'(fill_reg - FILL_W'(2));
                if (top_ge)
                begin
                    fill_next = fill_reg - FILL_W'(1);
                    if (fill_reg != FILL_W'(1))
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_PUSH;
                    end
                end
                else
                begin
                    has_next   = 1'b1;
                    near_next  = rd_pos;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (push_go)
                begin
                    wr_en         = ~full;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (last_reg)
                    begin
                        fill_next = '0;
                        scan_next = '0;
                        ovf_next  = 1'b0;
                    end
                    else
                    begin
                        fill_next = full ? fill_reg : fill_reg + FILL_W'(1);
                        scan_next = scan_reg + POS_W'(1);
                        ovf_next  = ovf_reg | full;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= COUNT_W'(1);
            scan_backward_reg <= 1'b0;
            keys_signed_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ELEMENT_COUNT: element_count_reg <= cfg_data;
                CFG_SCAN_BACKWARD: scan_backward_reg <= cfg_data[0];
                CFG_KEYS_SIGNED:   keys_signed_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            scan_reg     <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            scan_reg     <= scan_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
        has_reg  <= has_next;
        near_reg <= near_next;
        if (push_go)
        begin
            m_tdata_reg <= {near_reg, pos_reg};
            m_tuser_reg <= {ovf_reg | full, has_reg};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `NSV_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= DEPTH_FILL, "stack fill beyond depth")
    `NSV_ASSERT_NOW(a_cmp_nonempty, state_reg == ST_CMP, fill_reg != '0, "compare on empty stack")
    `NSV_ASSERT_NEXT(a_seq_clear, push_go && last_reg,
        fill_reg == '0 && scan_reg == '0 && !ovf_reg, "sequence end did not clear state")
    `NSV_ASSERT_NEXT(a_result_loaded, push_go, m_tvalid && state_reg == ST_IDLE,
        "result not presented after push")

endmodule

/* bench/nearest_smaller_value_stack_top_test.sv */
// testbench for the nearest smaller value stack: directed, count extreme, overflow, backpressure and random runs
module nearest_smaller_value_stack_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nsv_pkg::*;

    localparam int STACK_DEPTH  = 1024;
    localparam int KEY_WIDTH    = 32;
    localparam int MAX_ELEMENTS = 65536;
    localparam int SEQ_LIMIT    = (MAX_ELEMENTS < 65536) ? MAX_ELEMENTS : 65536;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int TARGET_KEYS  = 1450;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             has_smaller;
        logic [POS_W-1:0] nearest_position;
        logic             stack_overflow;
        logic             end_of_sequence;
    } nsv_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COUNT_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [2*POS_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    // local copy of the configuration and stack
    logic [COUNT_W-1:0]   seq_len_cfg;
    logic                 backward_cfg;
    logic                 signed_cfg;
    logic [31:0]          stack_key [STACK_DEPTH];
    logic [POS_W-1:0]     stack_pos [STACK_DEPTH];
    int unsigned          stack_fill;
    int unsigned          scan_idx;
    logic                 overflow_flag;

    nsv_result_t          expected_q[$];
    int                   mismatch_count;
    int                   keys_sent;
    bit                   send_idle_on;
    bit                   sink_idle_on;
    int                   hold_requests;
    int                   hold_served;
    int                   hold_left;

    nearest_smaller_value_stack_top #(
        .STACK_DEPTH  (STACK_DEPTH),
        .KEY_WIDTH    (KEY_WIDTH),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #4 clk = ~clk;

    function automatic nsv_result_t nearest_smaller_step(input logic [31:0] key);
        nsv_result_t r;
        int unsigned n;
        logic [31:0] flip;
        logic [31:0] ord;
        n = (seq_len_cfg == 0) ? 1 : ((seq_len_cfg > SEQ_LIMIT) ? SEQ_LIMIT : seq_len_cfg);
        flip = signed_cfg ? 32'h8000_0000 : 32'h0;
        ord = key ^ flip;
        r = '0;
        r.position = backward_cfg ? POS_W'(n - 1 - scan_idx) : POS_W'(scan_idx);
        while (stack_fill > 0 && (stack_key[stack_fill-1] ^ flip) >= ord)
            stack_fill--;
        if (stack_fill > 0)
        begin
            r.has_smaller = 1'b1;
            r.nearest_position = stack_pos[stack_fill-1];
        end
        if (stack_fill < STACK_DEPTH)
        begin
            stack_key[stack_fill] = key;
            stack_pos[stack_fill] = r.position;
            stack_fill++;
        end
        else
        begin
            overflow_flag = 1'b1;
        end
        r.stack_overflow = overflow_flag;
        r.end_of_sequence = (scan_idx + 1) >= n;
        if (r.end_of_sequence)
        begin
            stack_fill = 0;
            scan_idx = 0;
            overflow_flag = 1'b0;
        end
        else
        begin
            scan_idx = (scan_idx + 1) & 32'hFFFF;
        end
        return r;
    endfunction

    // result checker and receiver with random stalls
    always @(posedge clk)
    begin
        nsv_result_t got;
        nsv_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.position = m_tdata[POS_W-1:0];
            got.nearest_position = m_tdata[2*POS_W-1:POS_W];
            got.has_smaller = m_tuser[0];
            got.stack_overflow = m_tuser[1];
            got.end_of_sequence = m_tlast;
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: pos %0d near %0d has %0b ovf %0b last %0b",
                             got.position, got.nearest_position, got.has_smaller,
                             got.stack_overflow, got.end_of_sequence);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp pos %0d near %0d has %0b ovf %0b last %0b, ",
                                  "act pos %0d near %0d has %0b ovf %0b last %0b"},
                                 want.position, want.nearest_position, want.has_smaller,
                                 want.stack_overflow, want.end_of_sequence,
                                 got.position, got.nearest_position, got.has_smaller,
                                 got.stack_overflow, got.end_of_sequence);
                end
            end
        end
        if (hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !(sink_idle_on && $urandom_range(99) < 22);
        end
    end

    task automatic send_key(input logic [31:0] key);
        while (send_idle_on && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= key;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.push_back(nearest_smaller_step(key));
        keys_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ELEMENT_COUNT: seq_len_cfg = val;
            CFG_SCAN_BACKWARD: backward_cfg = val[0];
            CFG_KEYS_SIGNED:   signed_cfg = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_config(input logic [COUNT_W-1:0] count, input logic backward,
                              input logic signed_keys);
        write_reg(CFG_ELEMENT_COUNT, count);
        write_reg(CFG_SCAN_BACKWARD, {16'h0, backward});
        write_reg(CFG_KEYS_SIGNED, {16'h0, signed_keys});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed_basics();
        logic [31:0] unsigned_keys [8];
        logic [31:0] signed_keys [6];
        unsigned_keys = '{32'd5, 32'd3, 32'd3, 32'd7, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1};
        signed_keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'd1};
        // reset settings: one element per sequence
        send_key(32'd0);
        wait_drained();
        write_reg(CFG_UNUSED, 17'h1FFFF);
        set_config(17'd0, 1'b0, 1'b0);
        send_key(32'hFFFF_FFFF);
        wait_drained();
        set_config(17'd8, 1'b0, 1'b0);
        foreach (unsigned_keys[i])
            send_key(unsigned_keys[i]);
        wait_drained();
        set_config(17'd6, 1'b1, 1'b1);
        foreach (signed_keys[i])
            send_key(signed_keys[i]);
        wait_drained();
    endtask

    task automatic test_count_extremes();
        // count above the limit clamps, then lowered below the scan counter
        set_config(17'h1FFFF, 1'b1, 1'b0);
        send_key(32'd10);
        send_key(32'd20);
        send_key(32'd30);
        wait_drained();
        write_reg(CFG_ELEMENT_COUNT, 17'd2);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_key(32'd40);
        wait_drained();
        set_config(17'd65536, 1'b0, 1'b1);
        send_key(32'h7FFF_FFFF);
        send_key(32'h8000_0000);
        wait_drained();
        write_reg(CFG_ELEMENT_COUNT, 17'd1);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_key(32'd0);
        wait_drained();
    endtask

    task automatic test_stack_overflow();
        send_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        set_config(17'(STACK_DEPTH + 6), 1'b0, 1'b0);
        for (int i = 0; i < STACK_DEPTH + 6; i++)
            send_key(32'(i + 1) * 32'd4_000_000);
        wait_drained();
        send_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        set_config(17'd20, 1'b1, 1'b0);
        hold_requests++;
        for (int i = 0; i < 20; i++)
            send_key($urandom_range(15));
        wait_drained();
    endtask

    task automatic test_random_sequences();
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] flag_data;
        int unsigned pick;
        int unsigned n_keys;
        int unsigned style;
        logic [31:0] key;
        logic [31:0] stride;
        while (keys_sent < TARGET_KEYS)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                count = COUNT_W'($urandom_range(24, 1));
            else if (pick < 85)
                count = COUNT_W'($urandom_range(200, 25));
            else if (pick < 95)
                count = '0;
            else
                count = COUNT_W'($urandom_range(131071, 65536));
            write_reg(CFG_ELEMENT_COUNT, count);
            flag_data = ($urandom_range(4) == 0) ? 17'($urandom) : 17'($urandom_range(1));
            write_reg(CFG_SCAN_BACKWARD, flag_data);
            flag_data = ($urandom_range(4) == 0) ? 17'($urandom) : 17'($urandom_range(1));
            write_reg(CFG_KEYS_SIGNED, flag_data);
            cfg_valid <= 1'b0;
            @(posedge clk);
            // mostly whole sequences, some cut short
            if (count > 200)
                n_keys = $urandom_range(5, 1);
            else if ($urandom_range(4) == 0)
                n_keys = $urandom_range(count == 0 ? 1 : count, 1);
            else
                n_keys = (count == 0) ? 1 : count;
            style = $urandom_range(5);
            key = $urandom;
            stride = $urandom_range(1 << 20, 1);
            for (int i = 0; i < n_keys; i++)
            begin
                case (style)
                    0: key = $urandom_range(7);
                    1: key = $urandom;
                    2: key = 32'h7FFF_FFF8 + $urandom_range(15);
                    3: key = key + stride;
                    4: key = key - stride;
                    default: key = ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom;
                endcase
                send_key(key);
            end
            wait_drained();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        seq_len_cfg = 17'd1;
        backward_cfg = 1'b0;
        signed_cfg = 1'b0;
        stack_fill = 0;
        scan_idx = 0;
        overflow_flag = 1'b0;
        mismatch_count = 0;
        keys_sent = 0;
        send_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_count_extremes();
        test_stack_overflow();
        test_backpressure();
        test_random_sequences();
        wait_drained();
        mismatch_count += expected_q.size();
        if (mismatch_count == 0)
            $display("nearest_smaller_value_stack_top_test: PASS");
        else
            $display("nearest_smaller_value_stack_top_test: FAIL");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("nearest_smaller_value_stack_top_test: FAIL");
        $finish;
    end

endmodule
